/* hw/rtl/ewff_pkg.sv */
package ewff_pkg;

    // Default parameter values.
    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam int ACCEL_FRAC_BITS_DEF = 16;

    // Field and register widths.
    localparam int CRD_W      = 18;
    localparam int PRAD_W     = 8;
    localparam int WIN_W      = 13;
    localparam int DCFG_W     = 18;
    localparam int STEP_W     = 12;
    localparam int WR_W       = 24;
    localparam int ACC_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Datapath widths.
    localparam int MAG_W  = 18;   // |particle - source|
    localparam int OFF_W  = 24;   // |offset from front|
    localparam int SQ_W   = 50;   // square root radicand
    localparam int ROOT_W = 25;   // square root result
    localparam int OP_W   = 25;   // multiplier operand
    localparam int PROD_W = 50;   // multiplier product
    localparam int RNUM_W = 42;   // wave_radius * |delta|
    localparam int DEN_W  = 55;   // 20 * d^2
    localparam int Q_W    = 32;   // kept quotient bits

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SOURCE_X      = 3'd0;
    localparam cfg_idx_t CFG_SOURCE_Y      = 3'd1;
    localparam cfg_idx_t CFG_WINDOW_WIDTH  = 3'd2;
    localparam cfg_idx_t CFG_WINDOW_HEIGHT = 3'd3;
    localparam cfg_idx_t CFG_MAX_DISTANCE  = 3'd4;
    localparam cfg_idx_t CFG_MIN_DISTANCE  = 3'd5;
    localparam cfg_idx_t CFG_WAVE_STEP     = 3'd6;

    // Multiplier operand selection.
    typedef enum logic [2:0] {
        MUL_DELTA_SQ,
        MUL_RADIUS,
        MUL_OFFSET_SQ,
        MUL_DIST_SQ,
        MUL_FORCE
    } mul_sel_t;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_DSQ,
        ST_SQ1_GO,
        ST_SQ1_WAIT,
        ST_MUL_RAD,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_OFFSET,
        ST_MUL_OSQ,
        ST_SQ2_GO,
        ST_SQ2_WAIT,
        ST_MUL_D,
        ST_DEN,
        ST_FX_GO,
        ST_FX_WAIT,
        ST_FY_GO,
        ST_FY_WAIT,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sq_start;
        logic     cap_size;
        logic     cap_dist;
        logic     div_start;
        logic     div_force;
        logic     div_y;
        logic     cap_step_x;
        logic     cap_step_y;
        logic     clr_step;
        logic     offset_en;
        logic     den_en;
        logic     cap_acc_x;
        logic     cap_acc_y;
        logic     out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sq_busy;
        logic sq_done;
        logic div_busy;
        logic div_done;
        logic size_zero;
    } sts_t;

endpackage

/* hw/rtl/expanding_wave_force_field.sv */
// Channel   Handshake                Payload
// input     in_valid / in_stall      particle_x, particle_y, particle_radius, last_in_frame
// output    out_valid / out_stall    accel_x_add, accel_y_add, set_relax, wave_alive
// config    cfg_we                   cfg_index, cfg_data
//
// One word is worked on at a time, using the shared bit-serial divider (up to four
// divisions) and the shared square root unit (two roots, one result bit per cycle).
// Reset is asynchronous and active low; it clears the controller, the wave radius
// and loads the configuration defaults.
// A stalled output word stays in its register; the next input word is still taken.
module expanding_wave_force_field
    import ewff_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int ACCEL_FRAC_BITS = ACCEL_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [CRD_W-1:0] particle_x,
    input  logic signed [CRD_W-1:0] particle_y,
    input  logic [PRAD_W-1:0]       particle_radius,
    input  logic                    last_in_frame,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [ACC_W-1:0] accel_x_add,
    output logic signed [ACC_W-1:0] accel_y_add,
    output logic                    set_relax,
    output logic                    wave_alive,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    ewff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic, configuration and frame state.
    ewff_dp #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .ACCEL_FRAC_BITS (ACCEL_FRAC_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .particle_x      (particle_x),
        .particle_y      (particle_y),
        .particle_radius (particle_radius),
        .last_in_frame   (last_in_frame),
        .cmd             (cmd),
        .sts             (sts),
        .accel_x_add     (accel_x_add),
        .accel_y_add     (accel_y_add),
        .set_relax       (set_relax),
        .wave_alive      (wave_alive)
    );

endmodule

/* hw/rtl/ewff_sqrt.sv */
module ewff_sqrt
    import ewff_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output logic              busy,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [SQ_W-1:0] v_reg, v_next;
    logic [SQ_W-1:0] r_reg, r_next;
    logic [SQ_W-1:0] bit_reg, bit_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SQ_W:0]   trial;

    // One result bit per cycle, two radicand bits per step.
    always_comb
    begin
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, r_reg} + {1'b0, bit_reg};
        if (start)
        begin
            v_next    = radicand;
            r_next    = '0;
            bit_next  = SQ_W'(1) << (SQ_W - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next = v_reg - trial[SQ_W-1:0];
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];

endmodule

/* hw/rtl/ewff_div.sv */
module ewff_div
    import ewff_pkg::*;
#(
    parameter int NUM_W = RNUM_W + ACCEL_FRAC_BITS_DEF,
    parameter int CNT_W = $clog2(NUM_W + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [CNT_W-1:0] iters,
    output logic             busy,
    output logic             done,
    output logic [Q_W-1:0]   quo,
    output logic             ovf
);

    logic [NUM_W-1:0] n_reg, n_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [DEN_W-1:0] r_reg, r_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    // Restoring division, one quotient bit per cycle, numerator taken MSB first.
    // Quotient bits above the kept width only set the overflow flag.
    always_comb
    begin
        n_next    = n_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg, n_reg[NUM_W-1]};
        diff      = shifted - {1'b0, d_reg};
        if (start)
        begin
            n_next    = num;
            d_next    = den;
            r_next    = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            cnt_next  = iters;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                r_next = diff[DEN_W-1:0];
                q_next = {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[DEN_W-1:0];
                q_next = {q_reg[Q_W-2:0], 1'b0};
            end
            ovf_next = ovf_reg | q_reg[Q_W-1];
            n_next   = n_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = q_reg;
    assign ovf  = ovf_reg;

endmodule

/* hw/rtl/ewff_dp.sv */
module ewff_dp
    import ewff_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int ACCEL_FRAC_BITS = ACCEL_FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [CRD_W-1:0]      particle_x,
    input  logic signed [CRD_W-1:0]      particle_y,
    input  logic [PRAD_W-1:0]            particle_radius,
    input  logic                         last_in_frame,
    input  cmd_t                         cmd,
    output sts_t                         sts,
    output logic signed [ACC_W-1:0]      accel_x_add,
    output logic signed [ACC_W-1:0]      accel_y_add,
    output logic                         set_relax,
    output logic                         wave_alive
);

    localparam int NUM_W = RNUM_W + ACCEL_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int REL_W = 19 + COORD_FRAC_BITS;

    // Configuration registers.
    logic signed [CRD_W-1:0] src_x_reg, src_y_reg;
    logic [WIN_W-1:0]        win_w_reg, win_h_reg;
    logic [DCFG_W-1:0]       max_d_reg, min_d_reg;
    logic [STEP_W-1:0]       step_cfg_reg;

    // Frame state.
    logic [WR_W-1:0] wr_reg, wr_next;
    logic            alive_reg, alive_next;

    // Item registers.
    logic signed [CRD_W-1:0] px_reg, py_reg;
    logic [PRAD_W-1:0]       prad_reg;
    logic                    last_reg;
    logic [MAG_W-1:0]        dx_mag_reg, dy_mag_reg;
    logic                    dx_neg_reg, dy_neg_reg;
    logic [ROOT_W-1:0]       size_reg, dist_reg;
    logic                    hit_reg;
    logic [OFF_W-1:0]        step_x_reg, step_y_reg;
    logic [OFF_W-1:0]        ox_mag_reg, oy_mag_reg;
    logic                    ox_neg_reg, oy_neg_reg;
    logic [PROD_W-1:0]       prod_a_reg, prod_b_reg;
    logic [DEN_W-1:0]        den_reg;
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg;

    // Output word.
    logic signed [ACC_W-1:0] out_ax_reg, out_ay_reg;
    logic                    out_relax_reg, out_alive_reg;

    // Combinational signals.
    logic signed [CRD_W:0]   dx, dy;
    logic [CRD_W:0]          dx_abs, dy_abs;
    logic signed [OFF_W:0]   diff_x, diff_y;
    logic [OFF_W:0]          diff_x_abs, diff_y_abs;
    logic [ROOT_W-1:0]       d_clamp;
    logic [OP_W-1:0]         op_a1, op_a2, op_b1, op_b2;
    logic [PROD_W-1:0]       sel_prod;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic [CNT_W-1:0]        div_iters;
    logic [Q_W-2:0]          force_mag;
    logic signed [ACC_W-1:0] force_val;
    logic                    force_neg;
    logic [WR_W:0]           wr_sum;
    logic                    alive_now;
    logic                    relax;
    logic signed [REL_W-1:0] px_e, py_e, lo_b, hi_x, hi_y;

    // Unit interfaces.
    logic              sq_busy, sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic              div_busy, div_done, div_ovf;
    logic [Q_W-1:0]    div_quo;

    // Delta from the source, split into magnitude and sign.
    always_comb
    begin
        dx     = (CRD_W + 1)'(particle_x) - (CRD_W + 1)'(src_x_reg);
        dy     = (CRD_W + 1)'(particle_y) - (CRD_W + 1)'(src_y_reg);
        dx_abs = dx[CRD_W] ? (CRD_W + 1)'(-dx) : (CRD_W + 1)'(dx);
        dy_abs = dy[CRD_W] ? (CRD_W + 1)'(-dy) : (CRD_W + 1)'(dy);
    end

    // Offset from the front: |delta| - step, sign flipped for negative deltas.
    always_comb
    begin
        diff_x     = $signed({{(OFF_W - MAG_W + 1){1'b0}}, dx_mag_reg})
                     - $signed({1'b0, step_x_reg});
        diff_y     = $signed({{(OFF_W - MAG_W + 1){1'b0}}, dy_mag_reg})
                     - $signed({1'b0, step_y_reg});
        diff_x_abs = diff_x[OFF_W] ? (OFF_W + 1)'(-diff_x) : (OFF_W + 1)'(diff_x);
        diff_y_abs = diff_y[OFF_W] ? (OFF_W + 1)'(-diff_y) : (OFF_W + 1)'(diff_y);
    end

    // Distance clamped up to min_distance and at least one.
    always_comb
    begin
        d_clamp = dist_reg;
        if (d_clamp < ROOT_W'(min_d_reg))
        begin
            d_clamp = ROOT_W'(min_d_reg);
        end
        if (d_clamp == '0)
        begin
            d_clamp = ROOT_W'(1);
        end
    end

    // Operand selection for the two shared multipliers.
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DELTA_SQ:
            begin
                op_a1 = OP_W'(dx_mag_reg);
                op_a2 = OP_W'(dx_mag_reg);
                op_b1 = OP_W'(dy_mag_reg);
                op_b2 = OP_W'(dy_mag_reg);
            end
            MUL_RADIUS:
            begin
                op_a1 = OP_W'(wr_reg);
                op_a2 = OP_W'(dx_mag_reg);
                op_b1 = OP_W'(wr_reg);
                op_b2 = OP_W'(dy_mag_reg);
            end
            MUL_OFFSET_SQ:
            begin
                op_a1 = OP_W'(ox_mag_reg);
                op_a2 = OP_W'(ox_mag_reg);
                op_b1 = OP_W'(oy_mag_reg);
                op_b2 = OP_W'(oy_mag_reg);
            end
            MUL_DIST_SQ:
            begin
                op_a1 = OP_W'(d_clamp);
                op_a2 = OP_W'(d_clamp);
                op_b1 = '0;
                op_b2 = '0;
            end
            MUL_FORCE:
            begin
                op_a1 = OP_W'(ox_mag_reg);
                op_a2 = OP_W'(max_d_reg);
                op_b1 = OP_W'(oy_mag_reg);
                op_b2 = OP_W'(max_d_reg);
            end
            default:
            begin
                op_a1 = '0;
                op_a2 = '0;
                op_b1 = '0;
                op_b2 = '0;
            end
        endcase
    end

    // Divider operands: the step uses wave_radius*|delta| / size,
    // the force uses |offset|*max_distance*2^ACCEL_FRAC_BITS / (20 d^2).
    always_comb
    begin
        sel_prod  = cmd.div_y ? prod_b_reg : prod_a_reg;
        div_num   = {sel_prod[RNUM_W-1:0], {ACCEL_FRAC_BITS{1'b0}}};
        div_den   = cmd.div_force ? den_reg : DEN_W'(size_reg);
        div_iters = cmd.div_force ? CNT_W'(NUM_W) : CNT_W'(RNUM_W);
    end

    // Saturated, signed force from the quotient.
    always_comb
    begin
        force_neg = cmd.cap_acc_y ? oy_neg_reg : ox_neg_reg;
        force_mag = (div_ovf || div_quo[Q_W-1]) ? {(Q_W - 1){1'b1}} : div_quo[Q_W-2:0];
        force_val = force_neg ? -$signed({1'b0, force_mag}) : $signed({1'b0, force_mag});
    end

    // Window margin test, strict on both sides of both axes.
    always_comb
    begin
        px_e  = REL_W'(px_reg);
        py_e  = REL_W'(py_reg);
        lo_b  = $signed(REL_W'(prad_reg)) <<< COORD_FRAC_BITS;
        hi_x  = ($signed(REL_W'(win_w_reg)) - $signed(REL_W'(prad_reg))) <<< COORD_FRAC_BITS;
        hi_y  = ($signed(REL_W'(win_h_reg)) - $signed(REL_W'(prad_reg))) <<< COORD_FRAC_BITS;
        relax = (px_e > lo_b) && (px_e < hi_x) && (py_e > lo_b) && (py_e < hi_y);
    end

    // Frame state update when the word leaves.
    always_comb
    begin
        alive_now  = alive_reg | hit_reg;
        wr_sum     = (WR_W + 1)'(wr_reg) + (WR_W + 1)'(step_cfg_reg);
        wr_next    = wr_reg;
        alive_next = alive_reg;
        if (cmd.out_load)
        begin
            if (last_reg)
            begin
                alive_next = 1'b0;
                if (alive_now)
                begin
                    wr_next = wr_sum[WR_W] ? {WR_W{1'b1}} : wr_sum[WR_W-1:0];
                end
            end
            else
            begin
                alive_next = alive_now;
            end
        end
    end

    // Configuration and frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_x_reg    <= '0;
            src_y_reg    <= '0;
            win_w_reg    <= WIN_W'(1024);
            win_h_reg    <= WIN_W'(768);
            max_d_reg    <= DCFG_W'(20480);
            min_d_reg    <= DCFG_W'(1280);
            step_cfg_reg <= STEP_W'(64);
            wr_reg       <= '0;
            alive_reg    <= 1'b0;
        end
        else
        begin
            wr_reg    <= wr_next;
            alive_reg <= alive_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SOURCE_X:      src_x_reg    <= cfg_data[CRD_W-1:0];
                    CFG_SOURCE_Y:      src_y_reg    <= cfg_data[CRD_W-1:0];
                    CFG_WINDOW_WIDTH:  win_w_reg    <= cfg_data[WIN_W-1:0];
                    CFG_WINDOW_HEIGHT: win_h_reg    <= cfg_data[WIN_W-1:0];
                    CFG_MAX_DISTANCE:  max_d_reg    <= cfg_data[DCFG_W-1:0];
                    CFG_MIN_DISTANCE:  min_d_reg    <= cfg_data[DCFG_W-1:0];
                    CFG_WAVE_STEP:     step_cfg_reg <= cfg_data[STEP_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Item datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            px_reg     <= particle_x;
            py_reg     <= particle_y;
            prad_reg   <= particle_radius;
            last_reg   <= last_in_frame;
            dx_mag_reg <= dx_abs[MAG_W-1:0];
            dy_mag_reg <= dy_abs[MAG_W-1:0];
            dx_neg_reg <= dx[CRD_W];
            dy_neg_reg <= dy[CRD_W];
        end
        if (cmd.mul_en)
        begin
            prod_a_reg <= PROD_W'(op_a1) * PROD_W'(op_a2);
            prod_b_reg <= PROD_W'(op_b1) * PROD_W'(op_b2);
        end
        if (cmd.cap_size)
        begin
            size_reg <= sq_root;
        end
        if (cmd.cap_dist)
        begin
            dist_reg <= sq_root;
            hit_reg  <= sq_root < ROOT_W'(max_d_reg);
        end
        if (cmd.clr_step)
        begin
            step_x_reg <= '0;
            step_y_reg <= '0;
        end
        if (cmd.cap_step_x)
        begin
            step_x_reg <= div_quo[OFF_W-1:0];
        end
        if (cmd.cap_step_y)
        begin
            step_y_reg <= div_quo[OFF_W-1:0];
        end
        if (cmd.offset_en)
        begin
            ox_mag_reg <= diff_x_abs[OFF_W-1:0];
            oy_mag_reg <= diff_y_abs[OFF_W-1:0];
            ox_neg_reg <= dx_neg_reg ^ diff_x[OFF_W];
            oy_neg_reg <= dy_neg_reg ^ diff_y[OFF_W];
        end
        if (cmd.den_en)
        begin
            den_reg <= DEN_W'({prod_a_reg, 4'b0000}) + DEN_W'({prod_a_reg, 2'b00});
        end
        if (cmd.cap_acc_x)
        begin
            acc_x_reg <= force_val;
        end
        if (cmd.cap_acc_y)
        begin
            acc_y_reg <= force_val;
        end
        if (cmd.out_load)
        begin
            out_ax_reg    <= acc_x_reg;
            out_ay_reg    <= acc_y_reg;
            out_relax_reg <= relax;
            out_alive_reg <= last_reg & alive_now;
        end
    end

    // Shared square root unit.
    ewff_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sq_start),
        .radicand (prod_a_reg + prod_b_reg),
        .busy     (sq_busy),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Shared divider.
    ewff_div #(
        .NUM_W (NUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .iters (div_iters),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo),
        .ovf   (div_ovf)
    );

    // Status toward the controller.
    always_comb
    begin
        sts.sq_busy   = sq_busy;
        sts.sq_done   = sq_done;
        sts.div_busy  = div_busy;
        sts.div_done  = div_done;
        sts.size_zero = (size_reg == '0);
    end

    assign accel_x_add = out_ax_reg;
    assign accel_y_add = out_ay_reg;
    assign set_relax   = out_relax_reg;
    assign wave_alive  = out_alive_reg;

endmodule

/* hw/rtl/ewff_ctrl.sv */
module ewff_ctrl
    import ewff_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_DELTA_SQ;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL_DSQ;
                end
            end
            ST_MUL_DSQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DELTA_SQ;
                state_next  = ST_SQ1_GO;
            end
            ST_SQ1_GO:
            begin
                cmd.sq_start = 1'b1;
                state_next   = ST_SQ1_WAIT;
            end
            ST_SQ1_WAIT:
            begin
                if (sts.sq_done)
                begin
                    cmd.cap_size = 1'b1;
                    state_next   = ST_MUL_RAD;
                end
            end
            ST_MUL_RAD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RADIUS;
                // A particle on the source has no direction.
                if (sts.size_zero)
                begin
                    cmd.clr_step = 1'b1;
                    state_next   = ST_OFFSET;
                end
                else
                begin
                    state_next = ST_DIVX_GO;
                end
            end
            ST_DIVX_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVX_WAIT;
            end
            ST_DIVX_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_step_x = 1'b1;
                    state_next     = ST_DIVY_GO;
                end
            end
            ST_DIVY_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_y     = 1'b1;
                state_next    = ST_DIVY_WAIT;
            end
            ST_DIVY_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_step_y = 1'b1;
                    state_next     = ST_OFFSET;
                end
            end
            ST_OFFSET:
            begin
                cmd.offset_en = 1'b1;
                state_next    = ST_MUL_OSQ;
            end
            ST_MUL_OSQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_OFFSET_SQ;
                state_next  = ST_SQ2_GO;
            end
            ST_SQ2_GO:
            begin
                cmd.sq_start = 1'b1;
                state_next   = ST_SQ2_WAIT;
            end
            ST_SQ2_WAIT:
            begin
                if (sts.sq_done)
                begin
                    cmd.cap_dist = 1'b1;
                    state_next   = ST_MUL_D;
                end
            end
            ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DIST_SQ;
                state_next  = ST_DEN;
            end
            ST_DEN:
            begin
                cmd.den_en  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FORCE;
                state_next  = ST_FX_GO;
            end
            ST_FX_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_force = 1'b1;
                state_next    = ST_FX_WAIT;
            end
            ST_FX_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_acc_x = 1'b1;
                    state_next    = ST_FY_GO;
                end
            end
            ST_FY_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_force = 1'b1;
                cmd.div_y     = 1'b1;
                state_next    = ST_FY_WAIT;
            end
            ST_FY_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_acc_y = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Wait until the output register is free.
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // The square root unit is never restarted while it works.
    a_sq_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sq_start |-> !sts.sq_busy)
        else $error("square root started while busy");

    // The divider is never restarted while it works.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    // A new word never overwrites one that is still stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("output word overwritten");

    // An accepted word starts the computation.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_MUL_DSQ))
        else $error("accepted word did not start work");

    // A finished result raises the output valid on the next cycle.
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded word not valid");
`endif

endmodule

/* tb/tb_expanding_wave_force_field.sv */
`timescale 1ns / 1ps

module tb_expanding_wave_force_field;
    import ewff_pkg::*;

    localparam int CFRAC = COORD_FRAC_BITS_DEF;
    localparam int AFRAC = ACCEL_FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    // One result word of the block.
    typedef struct packed {
        logic signed [ACC_W-1:0] ax;
        logic signed [ACC_W-1:0] ay;
        logic                    relax;
        logic                    alive;
    } force_word_t;

    // Scoreboard: models the wave and holds the forces still to come out.
    class wave_scoreboard;
        logic signed [CRD_W-1:0] src_x, src_y;
        logic [WIN_W-1:0]        win_w, win_h;
        logic [DCFG_W-1:0]       max_d, min_d;
        logic [STEP_W-1:0]       step;
        logic [WR_W-1:0]         radius;
        bit                      seen;
        force_word_t             pending_forces[$];
        int                      errors;

        function new();
            src_x = '0; src_y = '0; win_w = 1024; win_h = 768;
            max_d = 20480; min_d = 1280; step = 64;
            radius = '0; seen = 0; errors = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_SOURCE_X:      src_x = v;
                CFG_SOURCE_Y:      src_y = v;
                CFG_WINDOW_WIDTH:  win_w = v[WIN_W-1:0];
                CFG_WINDOW_HEIGHT: win_h = v[WIN_W-1:0];
                CFG_MAX_DISTANCE:  max_d = v;
                CFG_MIN_DISTANCE:  min_d = v;
                CFG_WAVE_STEP:     step = v[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // Integer square root, floor.
        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function longint offset_from_front(longint delta, longint unsigned size);
            longint unsigned a, s;
            if (size == 0) return 0;
            a = (delta < 0) ? -delta : delta;
            s = (longint'(radius) * a) / size;
            return (delta < 0) ? delta + longint'(s) : delta - longint'(s);
        endfunction

        // Force along one axis, saturated in magnitude.
        function logic signed [ACC_W-1:0] axis_force(longint o, longint unsigned den);
            longint unsigned t, q, r;
            t = ((o < 0) ? -o : o) * longint'(max_d);
            q = t / den;
            r = t % den;
            for (int i = 0; i < AFRAC; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q = q | 1;
                end
            end
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            return (o < 0) ? ACC_W'(-longint'(q)) : ACC_W'(longint'(q));
        endfunction

        function void note_particle(logic signed [CRD_W-1:0] px, logic signed [CRD_W-1:0] py,
                                    logic [PRAD_W-1:0] rad, logic last);
            longint dx, dy, ox, oy, r16;
            longint unsigned size, dist_len, d;
            force_word_t w;
            dx = longint'(px) - longint'(src_x);
            dy = longint'(py) - longint'(src_y);
            size = int_sqrt(dx * dx + dy * dy);
            ox = offset_from_front(dx, size);
            oy = offset_from_front(dy, size);
            dist_len = int_sqrt(ox * ox + oy * oy);
            if (dist_len < max_d) seen = 1;
            d = dist_len;
            if (d < min_d) d = min_d;
            if (d == 0) d = 1;
            w.ax = axis_force(ox, 20 * d * d);
            w.ay = axis_force(oy, 20 * d * d);
            r16 = longint'(rad) << CFRAC;
            w.relax = (px > r16) && (px < ((longint'(win_w) << CFRAC) - r16)) &&
                      (py > r16) && (py < ((longint'(win_h) << CFRAC) - r16));
            w.alive = 0;
            if (last)
            begin
                w.alive = seen;
                if (seen)
                    radius = (longint'(radius) + step > 24'hFFFFFF) ?
                             24'hFFFFFF : radius + step;
                seen = 0;
            end
            pending_forces = {pending_forces, w};
        endfunction

        function void check_force(force_word_t got);
            force_word_t e;
            if (pending_forces.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            e = pending_forces.pop_front();
            if (got.ax !== e.ax)
            begin
                $display("%0t: accel_x_add expected %0d actual %0d", $time, e.ax, got.ax);
                errors++;
            end
            if (got.ay !== e.ay)
            begin
                $display("%0t: accel_y_add expected %0d actual %0d", $time, e.ay, got.ay);
                errors++;
            end
            if (got.relax !== e.relax)
            begin
                $display("%0t: set_relax expected %0b actual %0b", $time, e.relax, got.relax);
                errors++;
            end
            if (got.alive !== e.alive)
            begin
                $display("%0t: wave_alive expected %0b actual %0b", $time, e.alive, got.alive);
                errors++;
            end
        endfunction
    endclass

    logic                    clk = 0;
    logic                    rst_n = 0;
    logic                    in_valid = 0;
    logic                    in_stall;
    logic signed [CRD_W-1:0] particle_x = '0;
    logic signed [CRD_W-1:0] particle_y = '0;
    logic [PRAD_W-1:0]       particle_radius = '0;
    logic                    last_in_frame = 0;
    logic                    out_valid;
    logic                    out_stall = 0;
    logic signed [ACC_W-1:0] accel_x_add, accel_y_add;
    logic                    set_relax, wave_alive;
    logic                    cfg_we = 0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    wave_scoreboard sb = new();
    int send_idle_pct = 9;
    int recv_idle_pct = 72;
    int quiet_cycles = 0;

    expanding_wave_force_field i_dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Receiver stall and result checking.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_force({accel_x_add, accel_y_add, set_relax, wave_alive});
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog on cycles with no accepted word.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One register write, then the write enable is dropped again.
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // Sends one particle word and notes it on acceptance.
    task automatic send_particle(logic signed [CRD_W-1:0] px, logic signed [CRD_W-1:0] py,
                                 logic [PRAD_W-1:0] rad, logic last);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        in_valid <= 1;
        particle_x <= px;
        particle_y <= py;
        particle_radius <= rad;
        last_in_frame <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_particle(px, py, rad, last);
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending_forces.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly positions near the source, sometimes anywhere.
    task automatic random_frame(int n);
        logic signed [CRD_W-1:0] px, py;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                px = CRD_W'($urandom);
                py = CRD_W'($urandom);
            end
            else
            begin
                px = CRD_W'(sb.src_x + $signed(18'($urandom_range(8191))) - 4096);
                py = CRD_W'(sb.src_y + $signed(18'($urandom_range(8191))) - 4096);
            end
            send_particle(px, py, PRAD_W'($urandom), (i == n - 1));
        end
    endtask

    task automatic random_setting();
        write_reg(CFG_SOURCE_X, CFG_DATA_W'($urandom_range(16383)));
        write_reg(CFG_SOURCE_Y, CFG_DATA_W'($urandom_range(12287)));
        write_reg(CFG_WINDOW_WIDTH, CFG_DATA_W'($urandom_range(8191, 1)));
        write_reg(CFG_WINDOW_HEIGHT, CFG_DATA_W'($urandom_range(8191, 1)));
        write_reg(CFG_MAX_DISTANCE, CFG_DATA_W'($urandom));
        write_reg(CFG_MIN_DISTANCE, CFG_DATA_W'($urandom_range(4095)));
        write_reg(CFG_WAVE_STEP, CFG_DATA_W'($urandom));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed words at the reset setting: field extremes and the source itself.
        send_particle(0, 0, 0, 0);
        send_particle(18'sh1FFFF, 18'sh1FFFF, 255, 0);
        send_particle(-18'sh20000, -18'sh20000, 0, 0);
        send_particle(18'sh1FFFF, -18'sh20000, 255, 0);
        send_particle(400, 300, 1, 0);
        send_particle(1000, 800, 0, 1);
        // Growing wave over a few frames, front crossing a particle.
        for (int f = 0; f < 4; f++)
        begin
            send_particle(CRD_W'(64 * f), 0, 4, 0);
            send_particle(5000, 3000, 10, 1);
        end
        wait_drained();

        // Extreme setting: zero-ish clamps, huge force, radius past the window.
        write_reg(CFG_MIN_DISTANCE, 0);
        write_reg(CFG_MAX_DISTANCE, 18'h3FFFF);
        write_reg(CFG_WAVE_STEP, 18'hFFF);
        write_reg(CFG_WINDOW_WIDTH, 1);
        write_reg(CFG_WINDOW_HEIGHT, 18'h1FFF);
        write_reg(CFG_SOURCE_X, 18'h20000);
        write_reg(CFG_SOURCE_Y, 18'h1FFFF);
        send_particle(-18'sh20000, 18'sh1FFFF, 0, 0);
        send_particle(-18'sh1FFFF, 18'sh1FFFE, 200, 0);
        send_particle(18'sh1FFFF, -18'sh20000, 0, 1);
        wait_drained();
        write_reg(CFG_MAX_DISTANCE, 0);
        write_reg(CFG_MIN_DISTANCE, 18'h3FFFF);
        send_particle(5, 5, 0, 0);
        send_particle(0, 0, 0, 1);
        wait_drained();

        // Random frames across three idle profiles and fresh settings.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 72 : 0;
            recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 9 : 0;
            for (int k = 0; k < 4; k++)
            begin
                random_setting();
                for (int f = 0; f < 33; f++)
                    random_frame($urandom_range(8, 1));
                wait_drained();
            end
        end

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
